// ----- sv/radix_tree_lookup_insert_top_macros.svh -----
// ----------------------------------------------------------------------------
// Radix trie assertion macros
// Concurrent checks used by the trie lookup/insert block.
// ----------------------------------------------------------------------------
`ifndef RADIX_TREE_LOOKUP_INSERT_TOP_MACROS_SVH
`define RADIX_TREE_LOOKUP_INSERT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RTLI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rtli assertion failed");

// next-cycle implication
`define RTLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rtli assertion failed");

`else

`define RTLI_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RTLI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/rtli_pkg.sv -----
// ----------------------------------------------------------------------------
// Radix trie package
// Sizes, register indexes, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rtli_pkg;

    localparam int NODE_COUNT  = 64;
    localparam int MAX_RADIX   = 6;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int SLOT_W      = MAX_RADIX;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int ADDR_W      = NODE_W + SLOT_W;
    localparam int STORE_DEPTH = NODE_COUNT << SLOT_W;
    localparam int DATA_W      = (VALUE_WIDTH > NODE_W) ? VALUE_WIDTH : NODE_W;
    localparam int SHIFT_W     = $clog2(KEY_WIDTH);

    // configuration registers
    localparam int RADIX_W     = 3;
    localparam int KEYB_W      = 6;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int RADIX_RST   = 4;
    localparam int KEYB_RST    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BITS = 2'd1;

    typedef enum logic [1:0] {
        STAT_FOUND    = 2'd0,
        STAT_MISS     = 2'd1,
        STAT_INSERTED = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_CHECK,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/radix_tree_lookup_insert_top.sv -----
// ----------------------------------------------------------------------------
// Radix trie lookup / insert
// The trie is ceil(key_bits/radix) levels high. One item at a time: no new
// word is accepted until the result of the last one is in the output register.
// Each level costs a read of the slot memory (S_ADDR) and a check (S_CHECK).
// Reset and every write to the radix or key-bits register run a clearing pass
// over all 4096 slot memory words; no word is accepted until it ends.
// ----------------------------------------------------------------------------
// Fixed-height trie: node 0 is the root, interior slots hold child node
// numbers, leaf slots hold values. Find-or-insert allocates nodes in order.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_tree_lookup_insert_top_macros.svh"

module radix_tree_lookup_insert_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [rtli_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rtli_pkg::CFG_W-1:0]          i_cfg_data,
    // request channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_command,
    input  wire logic [rtli_pkg::KEY_WIDTH-1:0]      i_key,
    input  wire logic [rtli_pkg::VALUE_WIDTH-1:0]    i_new_value,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [1:0]                               o_status,
    output logic [rtli_pkg::VALUE_WIDTH-1:0]         o_value
);
    import rtli_pkg::*;

    t_state                 r_state, n_state;

    logic [RADIX_W-1:0]     r_radix;
    logic [KEYB_W-1:0]      r_key_bits;

    // clearing pass and height computation
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_hinit;
    logic [KEYB_W:0]        r_rem;
    logic [SHIFT_W-1:0]     r_top_shift;

    // walk state
    logic                   r_cmd;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_nv;
    logic [NODE_W-1:0]      r_node, n_node;
    logic [SHIFT_W-1:0]     r_shift, n_shift;
    logic [NODE_W:0]        r_nfree, n_nfree;
    logic [ADDR_W-1:0]      r_addr;
    logic [DATA_W:0]        r_rd_data;

    t_status                r_res_status, n_res_status;
    logic [VALUE_WIDTH-1:0] r_res_value, n_res_value;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [VALUE_WIDTH-1:0] r_out_value;

    logic [DATA_W:0]        r_mem [STORE_DEPTH];

    logic [RADIX_W-1:0]     w_eff_r;
    logic [KEYB_W:0]        w_eff_b;
    logic [SLOT_W-1:0]      w_smask;
    logic [KEY_WIDTH-1:0]   w_key_sh;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic                   w_cfg_hit;
    logic                   w_accept;
    logic                   w_out_take;
    logic                   w_h_done;
    logic                   w_rd_vld;
    logic                   w_last;
    logic                   w_step;
    logic                   w_finish;
    logic                   w_mem_we;
    logic [ADDR_W-1:0]      w_mem_waddr;
    logic [DATA_W:0]        w_mem_wdata;
    logic                   w_walk_we;

    // effective register values
    always_comb begin
        if (r_radix == '0) begin
            w_eff_r = RADIX_W'(1);
        end else if (int'(r_radix) > MAX_RADIX) begin
            w_eff_r = RADIX_W'(MAX_RADIX);
        end else begin
            w_eff_r = r_radix;
        end
        if (r_key_bits == '0) begin
            w_eff_b = (KEYB_W+1)'(1);
        end else if (int'(r_key_bits) > KEY_WIDTH) begin
            w_eff_b = (KEYB_W+1)'(KEY_WIDTH);
        end else begin
            w_eff_b = {1'b0, r_key_bits};
        end
    end

    assign w_smask    = SLOT_W'((1 << w_eff_r) - 1);
    assign w_key_sh   = r_key >> r_shift;
    assign w_rd_addr  = {r_node, w_key_sh[SLOT_W-1:0] & w_smask};
    assign w_cfg_hit  = i_cfg_we && (i_cfg_index == CFG_RADIX || i_cfg_index == CFG_KEY_BITS);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_take = !r_out_valid || !i_out_stall;
    assign w_h_done   = !r_hinit && (r_rem <= (KEYB_W+1)'(w_eff_r));

    assign w_rd_vld   = r_rd_data[DATA_W];
    assign w_last     = (r_shift == '0);

    // walk decision in the check cycle
    always_comb begin
        w_step       = 1'b0;
        w_finish     = 1'b0;
        w_walk_we    = 1'b0;
        w_mem_wdata  = '0;
        n_node       = r_node;
        n_shift      = r_shift;
        n_nfree      = r_nfree;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        if (r_state == S_CHECK) begin
            if (!w_last) begin
                if (w_rd_vld) begin
                    w_step  = 1'b1;
                    n_node  = r_rd_data[NODE_W-1:0];
                    n_shift = r_shift - SHIFT_W'(w_eff_r);
                end else if (r_cmd) begin
                    if (int'(r_nfree) >= NODE_COUNT) begin
                        w_finish     = 1'b1;
                        n_res_status = STAT_FULL;
                        n_res_value  = '0;
                    end else begin
                        w_step      = 1'b1;
                        w_walk_we   = 1'b1;
                        w_mem_wdata = {1'b1, DATA_W'(r_nfree[NODE_W-1:0])};
                        n_node      = r_nfree[NODE_W-1:0];
                        n_nfree     = r_nfree + 1'b1;
                        n_shift     = r_shift - SHIFT_W'(w_eff_r);
                    end
                end else begin
                    w_finish     = 1'b1;
                    n_res_status = STAT_MISS;
                    n_res_value  = '0;
                end
            end else begin
                w_finish = 1'b1;
                if (w_rd_vld) begin
                    n_res_status = STAT_FOUND;
                    n_res_value  = r_rd_data[VALUE_WIDTH-1:0];
                end else if (r_cmd) begin
                    w_walk_we    = 1'b1;
                    w_mem_wdata  = {1'b1, DATA_W'(r_nv)};
                    n_res_status = STAT_INSERTED;
                    n_res_value  = r_nv;
                end else begin
                    n_res_status = STAT_MISS;
                    n_res_value  = '0;
                end
            end
        end
    end

    // memory write port: clearing pass or walk
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
        end else begin
            w_mem_we    = w_walk_we;
            w_mem_waddr = r_addr;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1) && w_h_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_step) begin
                    n_state = S_ADDR;
                end else if (w_finish) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (w_cfg_hit) begin
            n_state = S_CLEAR;
        end
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = r_out_valid;
        o_status    = r_out_status;
        o_value     = r_out_value;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_radix     <= RADIX_W'(RADIX_RST);
            r_key_bits  <= KEYB_W'(KEYB_RST);
            r_clr_addr  <= '0;
            r_hinit     <= 1'b1;
            r_nfree     <= (NODE_W+1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == CFG_RADIX) begin
                r_radix <= i_cfg_data[RADIX_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_KEY_BITS) begin
                r_key_bits <= i_cfg_data[KEYB_W-1:0];
            end
            if (w_cfg_hit) begin
                r_clr_addr <= '0;
                r_hinit    <= 1'b1;
                r_nfree    <= (NODE_W+1)'(1);
            end else if (r_state == S_CLEAR) begin
                if (r_clr_addr != ADDR_W'(STORE_DEPTH - 1)) begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                r_hinit <= 1'b0;
                r_nfree <= (NODE_W+1)'(1);
            end else begin
                r_nfree <= n_nfree;
            end
            if (r_state == S_OUT && w_out_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // height: repeated subtraction of radix from key_bits, during the clear
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            if (r_hinit) begin
                r_rem       <= w_eff_b;
                r_top_shift <= '0;
            end else if (!w_h_done) begin
                r_rem       <= r_rem - (KEYB_W+1)'(w_eff_r);
                r_top_shift <= r_top_shift + SHIFT_W'(w_eff_r);
            end
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_cmd   <= i_command;
            r_key   <= i_key;
            r_nv    <= i_new_value;
            r_node  <= '0;
            r_shift <= r_top_shift;
        end else begin
            r_node  <= n_node;
            r_shift <= n_shift;
        end
        if (r_state == S_ADDR) begin
            r_addr <= w_rd_addr;
        end
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        if (r_state == S_OUT && w_out_take) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // never overwrite a slot that already holds a child or a value
    `RTLI_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, w_walk_we, !w_rd_vld)
    // pool counter stays within the node pool
    `RTLI_ASSERT_IMPLY(a_nfree_range, i_clk, i_rst_n, 1'b1,
        r_nfree != '0 && int'(r_nfree) <= NODE_COUNT)
    // an accepted word starts a walk at once
    `RTLI_ASSERT_NEXT(a_accept_walk, i_clk, i_rst_n, w_accept && !w_cfg_hit,
        r_state == S_ADDR && r_node == '0)
    // a register write restarts the clearing pass
    `RTLI_ASSERT_NEXT(a_cfg_clear, i_clk, i_rst_n, w_cfg_hit,
        r_state == S_CLEAR && r_clr_addr == '0)

endmodule

`default_nettype wire

// ----- verif/trie_result_checker.sv -----
// ----------------------------------------------------------------------------
// Radix trie result checker
// Watches the register port and both channels of the trie block, keeps its
// own copy of the trie and predicts every result word, then compares the
// returned words in order and counts failures for the testbench top.
// ----------------------------------------------------------------------------
module trie_result_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [rtli_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rtli_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_stall,
    input  wire logic                             i_command,
    input  wire logic [rtli_pkg::KEY_WIDTH-1:0]   i_key,
    input  wire logic [rtli_pkg::VALUE_WIDTH-1:0] i_new_value,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_stall,
    input  wire logic [1:0]                       i_status,
    input  wire logic [rtli_pkg::VALUE_WIDTH-1:0] i_value,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_found_count,
    output int                                    o_miss_count,
    output int                                    o_inserted_count,
    output int                                    o_full_count
);
    import rtli_pkg::*;

    localparam int SLOTS = 1 << MAX_RADIX;

    typedef struct packed {
        t_status                status;
        logic [VALUE_WIDTH-1:0] value;
    } t_trie_result;

    bit                     slot_used [STORE_DEPTH];
    logic [VALUE_WIDTH-1:0] slot_word [STORE_DEPTH];
    int                     free_node;
    logic [RADIX_W-1:0]     radix_reg;
    logic [KEYB_W-1:0]      keyb_reg;
    t_trie_result           trie_results_due [$];

    int fails    = 0;
    int n_found  = 0;
    int n_miss   = 0;
    int n_insert = 0;
    int n_full   = 0;

    function automatic void clear_trie();
        for (int a = 0; a < STORE_DEPTH; a++) slot_used[a] = 1'b0;
        free_node = 1;
    endfunction

    // one walk from the root; allocates interior nodes on insert
    function automatic t_trie_result walk_trie(input bit do_insert,
                                               input logic [KEY_WIDTH-1:0] key,
                                               input logic [VALUE_WIDTH-1:0] new_value);
        t_trie_result res;
        int           r;
        int           kb;
        int           level;
        int           node;
        int           addr;
        logic [63:0]  key64;
        logic [63:0]  smask;
        res.status = STAT_MISS;
        res.value  = '0;
        r = int'(radix_reg);
        if (r < 1) r = 1;
        if (r > MAX_RADIX) r = MAX_RADIX;
        kb = int'(keyb_reg);
        if (kb < 1) kb = 1;
        if (kb > KEY_WIDTH) kb = KEY_WIDTH;
        key64 = 64'(key);
        smask = (64'd1 << r) - 64'd1;
        node  = 0;
        // top level slice is full width even past key_bits
        for (level = (kb + r - 1) / r - 1; level > 0; level--) begin
            addr = node * SLOTS + int'((key64 >> (level * r)) & smask);
            if (slot_used[addr]) begin
                node = int'(slot_word[addr]);
            end else if (!do_insert) begin
                return res;
            end else if (free_node >= NODE_COUNT) begin
                res.status = STAT_FULL;
                return res;
            end else begin
                slot_used[addr] = 1'b1;
                slot_word[addr] = VALUE_WIDTH'(free_node);
                node            = free_node;
                free_node++;
            end
        end
        addr = node * SLOTS + int'(key64 & smask);
        if (slot_used[addr]) begin
            res.status = STAT_FOUND;
            res.value  = slot_word[addr];
        end else if (do_insert) begin
            slot_used[addr] = 1'b1;
            slot_word[addr] = new_value;
            res.status      = STAT_INSERTED;
            res.value       = new_value;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        t_trie_result due;
        if (!i_rst_n) begin
            radix_reg = RADIX_W'(RADIX_RST);
            keyb_reg  = KEYB_W'(KEYB_RST);
            clear_trie();
            trie_results_due.delete();
        end else begin
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (trie_results_due.size() == 0) begin
                    $error("result word with none outstanding: status %0d value 0x%08h",
                           i_status, i_value);
                    fails++;
                end else begin
                    due = trie_results_due.pop_front();
                    if (i_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, i_status);
                        fails++;
                    end
                    if (i_value !== due.value) begin
                        $error("value: expected 0x%08h, got 0x%08h", due.value, i_value);
                        fails++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                due = walk_trie(i_command, i_key, i_new_value);
                case (due.status)
                    STAT_FOUND:    n_found++;
                    STAT_MISS:     n_miss++;
                    STAT_INSERTED: n_insert++;
                    STAT_FULL:     n_full++;
                    default: ;
                endcase
                trie_results_due.push_back(due);
            end
            // a write to either register empties the trie; other indexes do nothing
            if (i_cfg_we === 1'b1) begin
                if (i_cfg_index == CFG_RADIX) begin
                    radix_reg = i_cfg_data[RADIX_W-1:0];
                    clear_trie();
                end else if (i_cfg_index == CFG_KEY_BITS) begin
                    keyb_reg = i_cfg_data[KEYB_W-1:0];
                    clear_trie();
                end
            end
        end
        o_pending        <= trie_results_due.size();
        o_fail_count     <= fails;
        o_found_count    <= n_found;
        o_miss_count     <= n_miss;
        o_inserted_count <= n_insert;
        o_full_count     <= n_full;
    end

endmodule

// ----- verif/tb_radix_tree_lookup_insert_top.sv -----
// ----------------------------------------------------------------------------
// Radix trie lookup / insert testbench
// Resets the block, runs a directed set of finds and inserts at the reset
// layout, then random traffic over a series of radix / key width settings
// with random gaps on both channels; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_radix_tree_lookup_insert_top;
    import rtli_pkg::*;

    localparam int RUN_LIMIT   = 1_000_000;
    localparam int SETTLE_WAIT = 4;
    localparam int END_WAIT    = 2 * KEY_WIDTH + 8;
    localparam int HOLD_CYCLES = 300;
    localparam bit CMD_FIND    = 1'b0;
    localparam bit CMD_INSERT  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_command;
    logic [KEY_WIDTH-1:0]   i_key;
    logic [VALUE_WIDTH-1:0] i_new_value;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [1:0]             o_status;
    logic [VALUE_WIDTH-1:0] o_value;

    int fail_count;
    int pending;
    int found_count;
    int miss_count;
    int inserted_count;
    int full_count;

    bit                   idle_on;
    bit                   hold_request;
    int                   sent_count;
    int                   layout_count;
    int                   cycles;
    logic [KEY_WIDTH-1:0] live_keys [$];

    radix_tree_lookup_insert_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_key       (i_key),
        .i_new_value (i_new_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_value     (o_value)
    );

    trie_result_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_key            (i_key),
        .i_new_value      (i_new_value),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_value          (o_value),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_found_count    (found_count),
        .o_miss_count     (miss_count),
        .o_inserted_count (inserted_count),
        .o_full_count     (full_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // holds valid and payload until the word is taken
    task automatic send_word(input bit cmd, input logic [KEY_WIDTH-1:0] key,
                             input logic [VALUE_WIDTH-1:0] val);
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_key       <= key;
        i_new_value <= val;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sent_count++;
        if (idle_on && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle(input int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly keys already in use or close to them, so walks share nodes
    task automatic random_word();
        int                     pick;
        bit                     cmd;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] val;
        pick = $urandom_range(0, 99);
        val  = ($urandom_range(0, 15) == 0) ? '0 : VALUE_WIDTH'($urandom());
        if (live_keys.size() == 0 || pick < 30) begin
            cmd = CMD_INSERT;
            key = KEY_WIDTH'($urandom());
        end else begin
            key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            if (pick < 55) begin
                cmd = CMD_FIND;
            end else if (pick < 72) begin
                cmd = CMD_INSERT;
                key ^= KEY_WIDTH'($urandom_range(1, 255));
            end else if (pick < 82) begin
                cmd = CMD_INSERT;
            end else if (pick < 92) begin
                cmd = CMD_FIND;
                key ^= KEY_WIDTH'($urandom_range(1, 255));
            end else begin
                cmd = CMD_FIND;
                key = KEY_WIDTH'($urandom());
            end
        end
        if (cmd == CMD_INSERT) live_keys.push_back(key);
        send_word(cmd, key, val);
    endtask

    task automatic run_phase(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input int words, input int hold_at, input int pause_at);
        settle(SETTLE_WAIT);
        write_reg(idx, data);
        if (idx == CFG_RADIX || idx == CFG_KEY_BITS) begin
            live_keys.delete();
            layout_count++;
        end
        for (int n = 0; n < words; n++) begin
            if (n == hold_at) hold_request = 1'b1;
            if (n == pause_at) settle(0);
            random_word();
        end
    endtask

    // result side: random stall bursts, plus one long hold on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 8) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_command    = CMD_FIND;
        i_key        = '0;
        i_new_value  = '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        sent_count   = 0;
        layout_count = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset layout: radix 4, 32 key bits, eight levels, 63 free nodes
        send_word(CMD_FIND,   32'h0000_0000, 32'h1111_1111);
        send_word(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_FIND,   32'h0000_0000, 32'h2222_2222);
        send_word(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);   // leaf kept
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 32'hFFFF_FFFE, 32'h1234_5678);
        send_word(CMD_FIND,   32'hFFFF_FFFE, 32'h0000_0000);
        send_word(CMD_FIND,   32'h0000_0001, 32'h0000_0000);   // misses at the leaf
        send_word(CMD_FIND,   32'h8000_0000, 32'h0000_0000);   // misses at the top
        send_word(CMD_INSERT, 32'h0000_0100, 32'hA5A5_A5A5);
        // distinct top slices drain the pool; the last one runs out midway
        for (int i = 1; i <= 7; i++) begin
            send_word(CMD_INSERT, KEY_WIDTH'((i << 28) | 32'h05A5_5A55),
                      VALUE_WIDTH'($urandom()));
        end
        send_word(CMD_FIND,   32'h75A5_5A55, 32'h0000_0000);
        send_word(CMD_INSERT, 32'h75A5_5A5A, 32'h0BAD_F00D);
        send_word(CMD_INSERT, 32'h8123_4567, 32'h0000_0001);
        send_word(CMD_FIND,   32'h35A5_5A55, 32'h0000_0000);

        run_phase(CFG_KEY_BITS, 6'd12, 120, 10, -1);
        run_phase(CFG_RADIX, CFG_W'(($urandom_range(0, 7) << 3) | 7), 120, -1, -1);
        run_phase(CFG_KEY_BITS, 6'd63, 120, -1, 60);
        run_phase(CFG_RADIX, CFG_W'($urandom_range(0, 7) << 3), 60, -1, -1);
        run_phase(CFG_KEY_BITS, 6'd5, 80, -1, -1);
        run_phase(CFG_RADIX, 6'd3, 80, -1, -1);
        run_phase(CFG_KEY_BITS, 6'd0, 80, -1, -1);
        idle_on = 1'b0;
        run_phase(CFG_RADIX, 6'd6, 60, -1, -1);
        idle_on = 1'b1;
        run_phase(CFG_KEY_BITS, 6'd32, 80, -1, -1);
        run_phase(CFG_RADIX, 6'd1, 60, -1, -1);
        run_phase(CFG_RADIX, 6'd5, 80, -1, -1);
        // spare indexes must leave the trie and layout alone
        settle(SETTLE_WAIT);
        write_reg(CFG_SPARE_2, CFG_W'($urandom()));
        idle_on = 1'b0;
        run_phase(CFG_SPARE_3, CFG_W'($urandom()), 80, -1, -1);

        settle(END_WAIT);
        $display("run: %0d words over %0d trie layouts, saturated and zero registers included",
                 sent_count, layout_count);
        $display("results: %0d found, %0d not found, %0d inserted, %0d pool exhausted",
                 found_count, miss_count, inserted_count, full_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- radix_tree_lookup_insert_top.f -----
+incdir+sv
sv/rtli_pkg.sv
sv/radix_tree_lookup_insert_top.sv
verif/trie_result_checker.sv
verif/tb_radix_tree_lookup_insert_top.sv
